[hw/rtl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, register indexes and channel arithmetic for the colorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

  typedef enum logic [2:0] {
    MODE_MONO    = 3'd0,
    MODE_SNAP    = 3'd1,
    MODE_BLEND   = 3'd2,
    MODE_CHASE   = 3'd3,
    MODE_RAINBOW = 3'd4
  } mode_t;

  localparam logic [2:0] REG_SHADE_MODE    = 3'd0;
  localparam logic [2:0] REG_PALETTE_COUNT = 3'd1;
  localparam logic [2:0] REG_PALETTE_0     = 3'd2;
  localparam logic [2:0] REG_PALETTE_1     = 3'd3;
  localparam logic [2:0] REG_PALETTE_2     = 3'd4;
  localparam logic [2:0] REG_PALETTE_3     = 3'd5;
  localparam logic [2:0] REG_HUE_RATE      = 3'd6;
  localparam logic [2:0] REG_SPATIAL_MIX   = 3'd7;

  localparam logic [23:0] DEFAULT_RED = 24'h0000FF;
  localparam logic [13:0] RECIP_100   = 14'd5243;   // 2^19 / 100, rounded up

  typedef struct packed {
    logic [2:0]  shade_mode;
    logic [2:0]  palette_count;
    logic [15:0] hue_rate;
    logic [8:0]  spatial_mix;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  n;
    logic        low_mix;
    logic [8:0]  v;
    logic [8:0]  m;
    logic [15:0] hue;
    logic [14:0] s;
    logic [14:0] mixed;
    logic [14:0] snapx;
    logic [14:0] blendx;
  } s1_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  n;
    logic        low_mix;
    logic [8:0]  v;
    logic [8:0]  m;
    logic [1:0]  i0;
    logic [1:0]  i1;
    logic [14:0] rem;
    logic        pick_hi;
    logic [8:0]  q_mixed;
    logic [8:0]  q_snap;
    logic [8:0]  q_blend;
    logic [2:0]  sector;
    logic [15:0] f;
  } s2_t;

  function automatic logic [8:0] sat256(input logic [8:0] x);
    return (x > 9'd256) ? 9'd256 : x;
  endfunction

  // Floor of x / 100 for x below 32768.
  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [28:0] p;
    p = {14'd0, x} * {15'd0, RECIP_100};
    return p[27:19];
  endfunction

  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [8:0] b);
    logic [16:0] p;
    p = {9'd0, c} * {8'd0, b};
    return (p[16:8] > 9'd255) ? 8'd255 : p[15:8];
  endfunction

  // a + (b - a) * t / 256, rounded toward zero.
  function automatic logic [7:0] lerp_chan(input logic [7:0] a, input logic [7:0] b,
                                           input logic [8:0] t);
    logic signed [9:0]  d;
    logic signed [19:0] p;
    logic [19:0]        mag;
    logic signed [10:0] q;
    logic signed [10:0] r;
    d   = $signed({2'b00, b}) - $signed({2'b00, a});
    p   = d * $signed({1'b0, t});
    mag = p[19] ? 20'(-p) : 20'(p);
    q   = p[19] ? -$signed({1'b0, mag[17:8]}) : $signed({1'b0, mag[17:8]});
    r   = $signed({3'b000, a}) + q;
    if (r < 0) return 8'd0;
    if (r > 255) return 8'd255;
    return r[7:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ppc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ppc_cfg_regs
// Configuration register file with plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_cfg_regs #(
  parameter int PALETTE_ENTRIES = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [23:0]   cfg_data,
  output ppc_pkg::cfg_t      cfg,
  output logic [23:0]        palette [PALETTE_ENTRIES]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shade_mode    <= 3'd1;
      cfg.palette_count <= 3'd2;
      cfg.hue_rate      <= 16'd100;
      cfg.spatial_mix   <= 9'd0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        palette[i] <= (i == 0) ? 24'h0000FF : ((i == 1) ? 24'hFF0000 : 24'h000000);
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        ppc_pkg::REG_SHADE_MODE:    cfg.shade_mode    <= cfg_data[2:0];
        ppc_pkg::REG_PALETTE_COUNT: cfg.palette_count <= cfg_data[2:0];
        ppc_pkg::REG_HUE_RATE:      cfg.hue_rate      <= cfg_data[15:0];
        ppc_pkg::REG_SPATIAL_MIX:   cfg.spatial_mix   <= cfg_data[8:0];
        default: begin
          for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            if (cfg_index == 3'(int'(ppc_pkg::REG_PALETTE_0) + i)) palette[i] <= cfg_data;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ppc_decode.sv]
// ----------------------------------------------------------------------------
// ppc_decode
// Stages one and two: input clamping, hue, drive and chase position math.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_decode #(
  parameter int PALETTE_ENTRIES = 4
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ppc_pkg::cfg_t cfg,
  input  wire logic [8:0]    level,
  input  wire logic [8:0]    phase,
  input  wire logic [8:0]    master_beat,
  input  wire logic [31:0]   time_stamp,
  output ppc_pkg::s2_t       s2
);

  ppc_pkg::s1_t s1;
  ppc_pkg::s1_t s1_next;
  ppc_pkg::s2_t s2_next;

  logic [8:0]  v, ph, m, mix;
  logic [31:0] hprod;
  logic [15:0] sraw;
  logic [17:0] u;
  logic [1:0]  i0;
  logic [1:0]  i1;
  logic [17:0] rem;
  logic [18:0] h6;

  always_comb begin
    v     = ppc_pkg::sat256(level);
    ph    = ppc_pkg::sat256(phase);
    m     = ppc_pkg::sat256(master_beat);
    mix   = ppc_pkg::sat256(cfg.spatial_mix);
    hprod = time_stamp[15:0] * cfg.hue_rate;
    sraw  = 16'(16'd100 * m) + 16'(16'd35 * ph);

    s1_next.mode    = (cfg.shade_mode > 3'd4) ? ppc_pkg::MODE_RAINBOW
                                              : ppc_pkg::mode_t'(cfg.shade_mode);
    s1_next.n       = (cfg.palette_count > 3'(PALETTE_ENTRIES)) ? 3'(PALETTE_ENTRIES)
                                                                : cfg.palette_count;
    s1_next.low_mix = mix < 9'd90;
    s1_next.v       = v;
    s1_next.m       = m;
    s1_next.hue     = 16'({ph, 8'd0}) + hprod[15:0];
    s1_next.s       = (sraw >= 16'd25600) ? 15'(sraw - 16'd25600) : sraw[14:0];
    s1_next.mixed   = 15'(15'd55 * m) + 15'(15'd45 * v);
    s1_next.snapx   = 15'd8960 + 15'(15'd65 * v);
    s1_next.blendx  = 15'd10240 + 15'(15'd60 * v);
  end

  always_comb begin
    u = {3'd0, s1.s} * {15'd0, s1.n};
    if (u >= 18'd76800) i0 = 2'd3;
    else if (u >= 18'd51200) i0 = 2'd2;
    else if (u >= 18'd25600) i0 = 2'd1;
    else i0 = 2'd0;
    if (s1.n != 3'd0 && {1'b0, i0} > s1.n - 3'd1) i0 = 2'(s1.n - 3'd1);
    rem = u - 18'(i0 * 18'd25600);
    i1  = ({1'b0, i0} + 3'd1 == s1.n) ? 2'd0 : 2'(i0 + 2'd1);
    h6  = 19'(s1.hue) * 19'd6;

    s2_next.mode    = s1.mode;
    s2_next.n       = s1.n;
    s2_next.low_mix = s1.low_mix;
    s2_next.v       = s1.v;
    s2_next.m       = s1.m;
    s2_next.i0      = i0;
    s2_next.i1      = i1;
    s2_next.rem     = rem[14:0];
    s2_next.pick_hi = s1.mixed >= 15'd12800;
    s2_next.q_mixed = ppc_pkg::div100(s1.mixed);
    s2_next.q_snap  = ppc_pkg::div100(s1.snapx);
    s2_next.q_blend = ppc_pkg::div100(s1.blendx);
    s2_next.sector  = h6[18:16];
    s2_next.f       = h6[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ppc_shade.sv]
// ----------------------------------------------------------------------------
// ppc_shade
// Stages three to five: colour selection, lerp, brightness and HSV output.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_shade #(
  parameter int PALETTE_ENTRIES = 4
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ppc_pkg::s2_t  s2,
  input  wire logic [23:0]   palette [PALETTE_ENTRIES],
  output logic [23:0]        color
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Stage three registers.
  logic        rb3;
  logic [2:0]  sec3;
  logic [24:0] vf3;
  logic [25:0] vd3;
  logic [7:0]  hi3;
  logic [23:0] a3, b3;
  logic [8:0]  t3, br3;
  // Stage four registers.
  logic        rb4;
  logic [2:0]  sec4;
  logic [7:0]  hi4, up4, dn4;
  logic [23:0] lc4;
  logic [8:0]  br4;

  logic [23:0] col0, colb, ca, cb;
  logic [8:0]  tsel, bsel, tq;
  logic [27:0] tp;
  logic        pick;
  logic [16:0] v255;
  logic [33:0] upx, dnx;
  logic [7:0]  r, g, b;
  logic [23:0] lc_next, color_next;

  always_comb begin
    col0 = (s2.n == 3'd0) ? ppc_pkg::DEFAULT_RED : palette[0];
    if (s2.n >= 3'd2 && PALETTE_ENTRIES > 1) colb = palette[IDX_W'(1)];
    else colb = {2'b00, col0[23:18], 2'b00, col0[15:10], 2'b00, col0[7:2]};
    tp   = {13'd0, s2.rem} * {14'd0, ppc_pkg::RECIP_100};
    tq   = tp[27:19];
    pick = s2.low_mix ? (s2.m >= 9'd128) : s2.pick_hi;
    ca = col0;
    cb = col0;
    tsel = 9'd0;
    bsel = s2.v;
    if (s2.mode == ppc_pkg::MODE_RAINBOW || s2.mode == ppc_pkg::MODE_MONO || s2.n == 3'd0) begin
      ca = col0;
    end else if (s2.mode == ppc_pkg::MODE_SNAP) begin
      ca   = pick ? colb : col0;
      cb   = ca;
      bsel = s2.q_snap;
    end else if (s2.mode == ppc_pkg::MODE_BLEND) begin
      cb   = colb;
      tsel = s2.low_mix ? s2.m : s2.q_mixed;
      bsel = s2.q_blend;
    end else begin
      ca   = palette[s2.i0[IDX_W-1:0]];
      cb   = palette[s2.i1[IDX_W-1:0]];
      tsel = tq;
    end
    v255 = {s2.v, 8'd0} - {8'd0, s2.v};
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lc_next[c*8 +: 8] = ppc_pkg::lerp_chan(a3[c*8 +: 8], b3[c*8 +: 8], t3);
    end
    upx = ({1'b0, vf3, 8'd0} - {9'd0, vf3}) + 34'd8388608;
    dnx = ({vd3, 8'd0} - {8'd0, vd3}) + 34'd8388608;
  end

  always_comb begin
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    unique case (sec4)
      3'd0:    begin r = hi4; g = up4; end
      3'd1:    begin r = dn4; g = hi4; end
      3'd2:    begin g = hi4; b = up4; end
      3'd3:    begin g = dn4; b = hi4; end
      3'd4:    begin r = up4; b = hi4; end
      default: begin r = hi4; b = dn4; end
    endcase
    if (rb4) begin
      color_next = {b, g, r};
    end else begin
      for (int c = 0; c < 3; c++) begin
        color_next[c*8 +: 8] = ppc_pkg::scale_chan(lc4[c*8 +: 8], br4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rb3   <= (s2.mode == ppc_pkg::MODE_RAINBOW);
      sec3  <= s2.sector;
      vf3   <= {16'd0, s2.v} * {9'd0, s2.f};
      vd3   <= {17'd0, s2.v} * (17'h10000 - {1'b0, s2.f});
      hi3   <= 8'((v255 + 17'd128) >> 8);
      a3    <= ca;
      b3    <= cb;
      t3    <= tsel;
      br3   <= bsel;
      rb4   <= rb3;
      sec4  <= sec3;
      hi4   <= hi3;
      up4   <= (upx[33:24] > 10'd255) ? 8'd255 : upx[31:24];
      dn4   <= (dnx[33:24] > 10'd255) ? 8'd255 : dnx[31:24];
      lc4   <= lc_next;
      br4   <= br3;
      color <= color_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pulse_palette_colorizer.sv]
// ----------------------------------------------------------------------------
// pulse_palette_colorizer
// Turns one LED sample into one packed 24-bit colour, five-stage pipeline.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------
//   sample   | sample_valid / sample_stall | level, phase, master_beat, time_stamp
//   color    | color_valid / color_stall   | color
//   config   | cfg_write                   | cfg_index, cfg_data
//
// A sample accepted at a clock edge moves through five register stages;
// color_valid rises when it reaches the last one. A new sample is accepted
// in every cycle in which the output is not stalled, for one result per
// cycle sustained. The whole pipeline advances on one enable, held only while
// a finished result waits at the output under stall; every stage then holds,
// and sample_stall is raised in that same cycle.
// Reset (rst, synchronous) clears all stage valid bits and loads the register
// defaults: duo snap, two palette entries, red then blue.
`default_nettype none

module pulse_palette_colorizer #(
  parameter int PALETTE_ENTRIES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        sample_valid,
  output logic             sample_stall,
  input  wire logic [8:0]  level,
  input  wire logic [8:0]  phase,
  input  wire logic [8:0]  master_beat,
  input  wire logic [31:0] time_stamp,
  output logic             color_valid,
  input  wire logic        color_stall,
  output logic [23:0]      color
);

  ppc_pkg::cfg_t cfg;
  ppc_pkg::s2_t  s2;
  logic [23:0]   palette [PALETTE_ENTRIES];
  logic [4:0]    vld;
  logic          en;

  // The only hold condition is a result at the last stage that is not taken.
  assign en           = !(vld[4] && color_stall);
  assign sample_stall = !en;
  assign color_valid  = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], sample_valid};
    end
  end

  ppc_cfg_regs #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_cfg (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg), .palette(palette)
  );

  // Stages one and two: clamping, hue, drive quotients and chase position.
  ppc_decode #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_decode (
    .clk(clk), .en(en), .cfg(cfg), .level(level), .phase(phase),
    .master_beat(master_beat), .time_stamp(time_stamp), .s2(s2)
  );

  // Stages three to five: colour pick, lerp, brightness and HSV output.
  ppc_shade #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_shade (
    .clk(clk), .en(en), .s2(s2), .palette(palette), .color(color)
  );

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse palette colorizer: a directed table of
// edge samples, then random samples under several register settings and
// handshake patterns, scored against a behavioral predictor or typed-in colors.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        sample_valid;
  logic        sample_stall;
  logic [8:0]  level;
  logic [8:0]  phase;
  logic [8:0]  master_beat;
  logic [31:0] time_stamp;
  logic        color_valid;
  logic        color_stall;
  logic [23:0] color;

  pulse_palette_colorizer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .level(level), .phase(phase), .master_beat(master_beat), .time_stamp(time_stamp),
    .color_valid(color_valid), .color_stall(color_stall), .color(color)
  );

  // Shadow copy of the register file, updated with every write we issue.
  logic [2:0]  sh_mode;
  logic [2:0]  sh_count;
  logic [23:0] sh_pal [4];
  logic [15:0] sh_rate;
  logic [8:0]  sh_mix;

  logic [23:0] pending_colors [$];
  int          errors;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clip256(int unsigned x);
    return (x > 256) ? 256 : x;
  endfunction

  function automatic logic [23:0] dim_color(logic [23:0] c, int unsigned b);
    logic [23:0] r;
    int unsigned k;
    for (int i = 0; i < 3; i++) begin
      k = (int'(c[8*i +: 8]) * b) >> 8;
      r[8*i +: 8] = (k > 255) ? 8'd255 : k[7:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] mix_color(logic [23:0] a, logic [23:0] b, int t);
    logic [23:0] r;
    int d;
    int q;
    int x;
    for (int i = 0; i < 3; i++) begin
      d = (int'(b[8*i +: 8]) - int'(a[8*i +: 8])) * t;
      q = (d < 0) ? -((-d) / 256) : d / 256;
      x = int'(a[8*i +: 8]) + q;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      r[8*i +: 8] = x[7:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] hue_to_rgb(int unsigned hue, int unsigned v);
    longint unsigned h6;
    longint unsigned f;
    longint unsigned hi;
    longint unsigned up;
    longint unsigned dn;
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    h6 = hue * 6;
    f  = h6 & 16'hFFFF;
    hi = (v * 255 + 128) >> 8;
    up = (v * f * 255 + (64'd1 << 23)) >> 24;
    dn = (v * (65536 - f) * 255 + (64'd1 << 23)) >> 24;
    case (h6 >> 16)
      0: begin r = hi; g = up; b = 0; end
      1: begin r = dn; g = hi; b = 0; end
      2: begin r = 0; g = hi; b = up; end
      3: begin r = 0; g = dn; b = hi; end
      4: begin r = up; g = 0; b = hi; end
      default: begin r = hi; g = 0; b = dn; end
    endcase
    if (r > 255) r = 255;
    if (g > 255) g = 255;
    if (b > 255) b = 255;
    return {b[7:0], g[7:0], r[7:0]};
  endfunction

  // Predicts the packed color for one sample under the shadow registers.
  function automatic logic [23:0] predict_color(logic [8:0] lv, logic [8:0] ph_in,
                                                 logic [8:0] mb, logic [31:0] ts);
    int unsigned v;
    int unsigned ph;
    int unsigned m;
    int unsigned n;
    int unsigned mix;
    int unsigned mixed;
    int unsigned s;
    int unsigned u;
    int unsigned i0;
    int unsigned i1;
    int unsigned hue;
    logic [2:0]  mode;
    logic [23:0] ca;
    logic [23:0] cb;
    logic [63:0] prod;
    bit          low_mix;
    v    = clip256(lv);
    ph   = clip256(ph_in);
    m    = clip256(mb);
    mode = (sh_mode > ppc_pkg::MODE_RAINBOW) ? ppc_pkg::MODE_RAINBOW : sh_mode;
    n    = (sh_count > 4) ? 4 : sh_count;
    mix  = clip256(sh_mix);
    if (mode == ppc_pkg::MODE_RAINBOW) begin
      prod = 64'(ts) * 64'(sh_rate);
      hue = ((ph << 8) + int'(prod[15:0])) & 16'hFFFF;
      return hue_to_rgb(hue, v);
    end
    if (mode == ppc_pkg::MODE_MONO || n == 0)
      return dim_color((n == 0) ? ppc_pkg::DEFAULT_RED : sh_pal[0], v);
    if (mode == ppc_pkg::MODE_SNAP || mode == ppc_pkg::MODE_BLEND) begin
      ca = sh_pal[0];
      cb = (n >= 2) ? sh_pal[1] : dim_color(ca, 64);
      low_mix = (mix * 20) < 1792;
      mixed = 55 * m + 45 * v;
      if (mode == ppc_pkg::MODE_SNAP)
        return dim_color((low_mix ? (m >= 128) : (mixed >= 12800)) ? cb : ca,
                         (35 * 256 + 65 * v) / 100);
      return dim_color(mix_color(ca, cb, low_mix ? m : clip256(mixed / 100)),
                       (40 * 256 + 60 * v) / 100);
    end
    // Chase walks the palette; a full turn of beat wraps to zero.
    s  = (100 * m + 35 * ph) % 25600;
    u  = s * n;
    i0 = u / 25600;
    if (i0 > n - 1) i0 = n - 1;
    i1 = (i0 + 1) % n;
    return dim_color(mix_color(sh_pal[i0 & 3], sh_pal[i1 & 3], (u % 25600) / 100), v);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      ppc_pkg::REG_SHADE_MODE:    sh_mode  = val[2:0];
      ppc_pkg::REG_PALETTE_COUNT: sh_count = val[2:0];
      ppc_pkg::REG_PALETTE_0:     sh_pal[0] = val;
      ppc_pkg::REG_PALETTE_1:     sh_pal[1] = val;
      ppc_pkg::REG_PALETTE_2:     sh_pal[2] = val;
      ppc_pkg::REG_PALETTE_3:     sh_pal[3] = val;
      ppc_pkg::REG_HUE_RATE:      sh_rate  = val[15:0];
      ppc_pkg::REG_SPATIAL_MIX:   sh_mix   = val[8:0];
      default: ;
    endcase
  endtask

  // Drops valid, then waits until every expected color has come back, plus
  // pipeline drain time.
  task automatic drain_pipeline();
    sample_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Offers one sample and holds it until accepted. When expect_in is set, the
  // typed-in color is queued instead of the predicted one. Valid stays high
  // after acceptance until the next offer replaces it or a drain takes it down.
  task automatic send_sample(logic [8:0] lv, logic [8:0] ph, logic [8:0] mb,
                             logic [31:0] ts, bit expect_in, logic [23:0] exp_col);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    level        <= lv;
    phase        <= ph;
    master_beat  <= mb;
    time_stamp   <= ts;
    pending_colors.push_back(expect_in ? exp_col : predict_color(lv, ph, mb, ts));
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  function automatic logic [8:0] rand_frac();
    case ($urandom_range(9))
      0: return 9'd0;
      1: return 9'd256;
      2: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(256));
    endcase
  endfunction

  task automatic random_samples(int count);
    for (int i = 0; i < count; i++)
      send_sample(rand_frac(), rand_frac(), rand_frac(), $urandom, 1'b0, 24'd0);
  endtask

  task automatic random_settings();
    write_reg(ppc_pkg::REG_SHADE_MODE, 24'($urandom_range(7)));
    write_reg(ppc_pkg::REG_PALETTE_COUNT, 24'($urandom_range(7)));
    for (int k = 0; k < 4; k++)
      write_reg(ppc_pkg::REG_PALETTE_0 + 3'(k), 24'($urandom));
    write_reg(ppc_pkg::REG_HUE_RATE, 24'($urandom_range(65535)));
    write_reg(ppc_pkg::REG_SPATIAL_MIX, 24'($urandom_range(511)));
  endtask

  // Directed rows. The flag marks rows whose color is read off directly.
  typedef struct {
    logic [8:0]  lv;
    logic [8:0]  ph;
    logic [8:0]  mb;
    logic [31:0] ts;
    bit          typed;
    logic [23:0] col;
  } sample_row_t;

  sample_row_t edge_rows [] = '{
    // Reset settings: duo snap with red and blue, master beat picks the color.
    '{9'd256, 9'd0,   9'd0,   32'd0, 1'b1, 24'h0000FF},
    '{9'd256, 9'd0,   9'd256, 32'd0, 1'b1, 24'hFF0000},
    '{9'd0,   9'd0,   9'd127, 32'd0, 1'b1, 24'h000058},
    '{9'd0,   9'd0,   9'd128, 32'd0, 1'b1, 24'h580000},
    '{9'd511, 9'd511, 9'd511, 32'hFFFFFFFF, 1'b1, 24'hFF0000},
    '{9'd100, 9'd33,  9'd200, 32'd77, 1'b0, 24'd0},
    '{9'd300, 9'd0,   9'd64,  32'd0, 1'b0, 24'd0}
  };

  sample_row_t mode_rows [] = '{
    '{9'd0,   9'd0,   9'd0,   32'd0, 1'b0, 24'd0},
    '{9'd256, 9'd256, 9'd256, 32'hFFFFFFFF, 1'b0, 24'd0},
    '{9'd128, 9'd128, 9'd128, 32'h8000_0000, 1'b0, 24'd0},
    '{9'd511, 9'd257, 9'd300, 32'd12345, 1'b0, 24'd0},
    '{9'd1,   9'd255, 9'd1,   32'd1, 1'b0, 24'd0}
  };

  // Output side: random stall and the scoreboard against the oldest entry.
  initial begin
    color_stall = 1'b1;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        color_stall <= 1'b1;
        repeat (40) @(posedge clk);
        hold_off = 1'b0;
      end
      color_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
      @(posedge clk);
      if (color_valid && !color_stall) begin
        if (pending_colors.size() == 0) begin
          $display("%0t: unexpected color transaction, actual %06h", $time, color);
          errors++;
        end else if (pending_colors[0] !== color) begin
          $display("%0t: color mismatch, expected %06h, actual %06h",
                   $time, pending_colors[0], color);
          errors++;
          void'(pending_colors.pop_front());
        end else begin
          void'(pending_colors.pop_front());
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (color_valid && !color_stall))
        idle_cycles = 0;
      else if (++idle_cycles > 5000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    errors        = 0;
    hold_off      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = ppc_pkg::REG_SHADE_MODE;
    cfg_data      = 24'd0;
    sample_valid  = 1'b0;
    level         = 9'd0;
    phase         = 9'd0;
    master_beat   = 9'd0;
    time_stamp    = 32'd0;
    sh_mode  = ppc_pkg::MODE_SNAP;
    sh_count = 3'd2;
    sh_pal[0] = 24'h0000FF;
    sh_pal[1] = 24'hFF0000;
    sh_pal[2] = 24'h0;
    sh_pal[3] = 24'h0;
    sh_rate  = 16'd100;
    sh_mix   = 9'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset defaults, then each mode with a full palette,
    // spatial mix saturated, and the empty and single-color palettes.
    foreach (edge_rows[i])
      send_sample(edge_rows[i].lv, edge_rows[i].ph, edge_rows[i].mb, edge_rows[i].ts,
                  edge_rows[i].typed, edge_rows[i].col);
    drain_pipeline();
    write_reg(ppc_pkg::REG_PALETTE_COUNT, 24'd7);
    write_reg(ppc_pkg::REG_PALETTE_2, 24'h00FF00);
    write_reg(ppc_pkg::REG_PALETTE_3, 24'hFFFFFF);
    write_reg(ppc_pkg::REG_SPATIAL_MIX, 24'd511);
    write_reg(ppc_pkg::REG_HUE_RATE, 24'hFFFF);
    for (int md = 0; md < 8; md++) begin
      write_reg(ppc_pkg::REG_SHADE_MODE, 24'(md));
      foreach (mode_rows[i])
        send_sample(mode_rows[i].lv, mode_rows[i].ph, mode_rows[i].mb, mode_rows[i].ts,
                    1'b0, 24'd0);
      drain_pipeline();
    end
    // Empty palette falls back to red scaled by level.
    write_reg(ppc_pkg::REG_SHADE_MODE, 24'(ppc_pkg::MODE_CHASE));
    write_reg(ppc_pkg::REG_PALETTE_COUNT, 24'd0);
    send_sample(9'd256, 9'd10, 9'd10, 32'd0, 1'b1, 24'h0000FF);
    send_sample(9'd128, 9'd10, 9'd10, 32'd0, 1'b1, 24'h00007F);
    drain_pipeline();
    // A single color in a duo mode pairs with itself at quarter brightness.
    write_reg(ppc_pkg::REG_SHADE_MODE, 24'(ppc_pkg::MODE_BLEND));
    write_reg(ppc_pkg::REG_PALETTE_COUNT, 24'd1);
    write_reg(ppc_pkg::REG_SPATIAL_MIX, 24'd0);
    send_sample(9'd256, 9'd0, 9'd256, 32'd0, 1'b0, 24'd0);
    send_sample(9'd40, 9'd0, 9'd90, 32'd0, 1'b0, 24'd0);
    drain_pipeline();

    // Random part in three handshake phases with fresh settings throughout.
    for (int ph_no = 0; ph_no < 3; ph_no++) begin
      send_idle_pct = (ph_no == 0) ? 22 : (ph_no == 1) ? 57 : 0;
      recv_idle_pct = (ph_no == 0) ? 57 : (ph_no == 1) ? 22 : 0;
      for (int set = 0; set < 9; set++) begin
        random_settings();
        if (set == 2) hold_off = 1'b1;
        random_samples(30);
        // The sender pauses until every expected color is back.
        drain_pipeline();
      end
    end

    drain_pipeline();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
